// ===== rtl/dtdf_pkg.sv =====
// Package for the double to dyadic fraction unit.
// Holds constants, status codes, controller state type and the control structs.
package dtdf_pkg;

    localparam int EXPONENT_BITS_DEFAULT = 8;
    localparam logic [5:0] LIMIT_BITS_RESET = 6'd31;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_EXACT = 2'd0,
        ST_LIMIT = 2'd1,
        ST_SATURATED = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_STEP,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;
        logic exact;
        logic at_limit;
        logic at_emax;
    } dp_stat_t;

endpackage

// ===== rtl/dtdf_datapath.sv =====
// Datapath of the double to dyadic fraction unit: decode, rounding, exponent counter.
// Depends on dtdf_pkg.
module dtdf_datapath
    import dtdf_pkg::*;
#(
    parameter int EXPONENT_BITS = EXPONENT_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic [63:0] value_bits,
    input  logic [5:0] limit_bits,
    input  dp_cmd_t cmd,
    output dp_stat_t stat,
    output logic [63:0] numerator,
    output logic [7:0] exponent
);

    logic [52:0] sig_reg;
    logic [11:0] shift_reg, shift_next;
    logic [11:0] exact_reg;
    logic [EXPONENT_BITS-1:0] e_reg;
    logic [63:0] num_reg, num_next;
    logic [63:0] limit_reg;
    logic invalid_reg;

    logic [63:0] mag;
    logic [10:0] bexp;
    logic [52:0] sig_in;
    logic [11:0] scale_in;
    logic [5:0] tz;
    logic [12:0] exf;
    logic bad;
    logic [11:0] e_wide;

    assign mag = value_bits & ~SIGN_BIT;
    assign bexp = mag[62:52];
    assign sig_in = (bexp == 11'd0) ? {1'b0, mag[51:0]} : {1'b1, mag[51:0]};
    assign scale_in = (bexp == 11'd0) ? 12'd1074 : (12'd1075 - {1'b0, bexp});
    assign bad = value_bits[63] ? (mag != 64'd0) : (mag > ONE_BITS);

    // Trailing zero count of the significand (zero significand handled separately).
    always_comb
    begin
        tz = 6'd0;
        for (int i = 52; i >= 0; i--)
        begin
            if (sig_in[i])
            begin
                tz = 6'(i);
            end
        end
    end

    assign exf = {1'b0, scale_in} - {7'd0, tz};

    // Rounding half away from zero of sig * 2^-shift.
    function automatic logic [63:0] round_scaled(input logic [52:0] s, input logic [11:0] sh);
        logic [52:0] q;
        logic [52:0] h;
        if (sh == 12'd0)
        begin
            return {11'd0, s};
        end
        if (sh >= 12'd54)
        begin
            return 64'd0;
        end
        q = s >> sh;
        h = s >> (sh - 12'd1);
        return {11'd0, q} + {63'd0, h[0]};
    endfunction

    assign shift_next = (cmd.load) ? scale_in : (shift_reg - 12'd1);
    assign num_next = round_scaled(cmd.load ? sig_in : sig_reg, shift_next);

    // Operand and iteration registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sig_reg <= sig_in;
            shift_reg <= scale_in;
            invalid_reg <= bad;
            exact_reg <= (sig_in == 53'd0 || exf[12]) ? 12'd0 : exf[11:0];
            e_reg <= '0;
            num_reg <= bad ? 64'd0 : num_next;
            limit_reg <= (64'd1 << limit_bits) - 64'd1;
        end
        else if (cmd.step)
        begin
            shift_reg <= shift_next;
            e_reg <= e_reg + {{(EXPONENT_BITS-1){1'b0}}, 1'b1};
            num_reg <= num_next;
        end
    end

    // The exponent counter widened to the exact-exponent width.
    assign e_wide = {{(12-EXPONENT_BITS){1'b0}}, e_reg};

    assign stat.invalid = invalid_reg;
    assign stat.exact = e_wide >= exact_reg;
    assign stat.at_limit = num_reg >= limit_reg;
    assign stat.at_emax = &e_reg;
    assign numerator = num_reg;
    assign exponent = e_wide[7:0];

endmodule

// ===== rtl/dtdf_ctrl.sv =====
// Controller of the double to dyadic fraction unit: sequences load, steps and result.
// Depends on dtdf_pkg.
module dtdf_ctrl
    import dtdf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic out_fire,
    input  dp_stat_t stat,
    output dp_cmd_t cmd,
    output logic busy,
    output logic result_valid,
    output status_t status
);

    state_t state_reg, state_next;
    status_t status_reg, status_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK, S_STEP:
            begin
                state_next = S_DONE;
                if (stat.invalid)
                begin
                    status_next = ST_INVALID;
                end
                else if (stat.exact)
                begin
                    status_next = ST_EXACT;
                end
                else if (stat.at_limit)
                begin
                    status_next = ST_LIMIT;
                end
                else if (stat.at_emax)
                begin
                    status_next = ST_SATURATED;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_DONE:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && in_fire;
        cmd.step = (state_next == S_STEP);
        busy = (state_reg != S_IDLE);
        result_valid = (state_reg == S_DONE);
        status = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            status_reg <= ST_EXACT;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== rtl/double_to_dyadic_fraction_unit.sv =====
// Double to dyadic fraction unit: converts a binary64 value in [0,1] to num / 2^exp.
// Throughput: one request at a time; the iteration loop does one rounding per cycle.
// Reset: rst_n asynchronous active low, clears control state; limit_bits resets to 31.
// Depends on dtdf_pkg, dtdf_ctrl and dtdf_datapath.
module double_to_dyadic_fraction_unit
    import dtdf_pkg::*;
#(
    parameter int EXPONENT_BITS = EXPONENT_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [63:0] s_tdata,   // value_bits[63:0]
    output logic m_tvalid,
    input  logic m_tready,
    output logic [79:0] m_tdata,   // numerator[63:0], exponent[71:64], status[73:72], zeros
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [0:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);

    logic [5:0] limit_reg;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic busy;
    status_t status;
    logic [63:0] numerator;
    logic [7:0] exponent;

    assign pready = 1'b1;
    assign prdata = {26'd0, limit_reg};

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_BITS_RESET;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            limit_reg <= pwdata[5:0];
        end
    end

    assign s_tready = !busy;

    dtdf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && s_tready),
        .out_fire(m_tvalid && m_tready), .stat(stat), .cmd(cmd), .busy(busy),
        .result_valid(m_tvalid), .status(status)
    );

    dtdf_datapath #(.EXPONENT_BITS(EXPONENT_BITS)) u_dp (
        .clk(clk), .value_bits(s_tdata), .limit_bits(limit_reg), .cmd(cmd),
        .stat(stat), .numerator(numerator), .exponent(exponent)
    );

    assign m_tdata = {6'd0, status, exponent, numerator};

    // No new request while a result waits.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    // A pending result stays stable until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
    // Invalid results carry zero payload.
    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[73:72] == ST_INVALID |-> m_tdata[71:0] == 72'd0)
        else $error("invalid result not zero");

endmodule

// ===== tb/double_to_dyadic_fraction_unit_test.sv =====
// Testbench for the double to dyadic fraction unit: stream stimulus, APB setup, result checks.
// Depends on dtdf_pkg and double_to_dyadic_fraction_unit.
`timescale 1ns / 100ps

module double_to_dyadic_fraction_unit_test;
    import dtdf_pkg::*;

    typedef struct packed {
        logic [63:0] numerator;
        logic [7:0]  exponent;
        status_t     status;
    } fraction_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;     // value_bits[63:0]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [79:0] m_tdata;          // numerator[63:0], exponent[71:64], status[73:72], zeros
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [0:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    logic [5:0] limit_bits = LIMIT_BITS_RESET;
    fraction_t expected_fractions[$];
    int errors = 0;
    int results_seen = 0;
    bit idle_enabled = 1'b1;

    double_to_dyadic_fraction_unit uut (.*);

    always #5 clk = ~clk;

    // Rounds sig * 2^-shift half away from zero.
    function automatic logic [63:0] round_down_by(logic [63:0] sig, longint shift);
        if (shift <= 0)
            return sig;
        if (shift >= 54)
            return 64'd0;
        return (sig >> shift) + ((sig >> (shift - 1)) & 64'd1);
    endfunction

    // Predicts the fraction for one value at the current limit.
    function automatic fraction_t convert_value(logic [63:0] bits);
        fraction_t r;
        logic [63:0] mag, sig, num, lim, s;
        longint scale, exact_from, e, tz;
        mag = bits & ~SIGN_BIT;
        r = '0;
        if (bits[63] ? (mag != 0) : (mag > ONE_BITS))
        begin
            r.status = ST_INVALID;
            return r;
        end
        if (mag[62:52] == 0)
        begin
            sig = {12'd0, mag[51:0]};
            scale = 1074;
        end
        else
        begin
            sig = {11'd0, 1'b1, mag[51:0]};
            scale = 1075 - longint'(mag[62:52]);
        end
        exact_from = 0;
        if (sig != 0)
        begin
            s = sig;
            tz = 0;
            while (!s[0])
            begin
                s = s >> 1;
                tz++;
            end
            exact_from = scale - tz;
            if (exact_from < 0)
                exact_from = 0;
        end
        lim = (64'd1 << limit_bits) - 64'd1;
        e = 0;
        num = round_down_by(sig, scale);
        forever
        begin
            if (e >= exact_from)
            begin
                r.status = ST_EXACT;
                break;
            end
            if (num >= lim)
            begin
                r.status = ST_LIMIT;
                break;
            end
            if (e >= longint'((1 << EXPONENT_BITS_DEFAULT) - 1))
            begin
                r.status = ST_SATURATED;
                break;
            end
            e++;
            num = round_down_by(sig, scale - e);
        end
        r.numerator = num;
        r.exponent = e[7:0];
        return r;
    endfunction

    // Sends one request and records its expected fraction.
    task automatic send_value(logic [63:0] bits);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= bits;
        expected_fractions = {expected_fractions, convert_value(bits)};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_fractions.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Writes limit_bits over APB; the block must be idle.
    task automatic write_limit(logic [5:0] bits);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {$urandom()} & 32'hFFFF_FFC0 | {26'd0, bits};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_bits = bits;
    endtask

    // Random value biased toward the interesting region of [0,1].
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v[62:52] = 11'd1023 - 11'($urandom_range(1, 12));
            4, 5: v[62:52] = 11'd1023 - 11'($urandom_range(13, 260));
            6: v[62:52] = 11'($urandom_range(0, 1));
            7: v = 64'h3FF0_0000_0000_0000;
            default: ;
        endcase
        if ($urandom_range(0, 9) != 0 && v != 64'h3FF0_0000_0000_0000)
            v[63] = 1'b0;
        if ($urandom_range(0, 3) != 0)
            v[31:0] = v[31:0] & ~((32'd1 << $urandom_range(0, 31)) - 32'd1);
        return v;
    endfunction

    // Result checker with random stalls on the master side.
    initial
    begin
        fraction_t got, want;
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (idle_enabled && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 16);
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[63:0], m_tdata[71:64], m_tdata[73:72]};
                results_seen++;
                if (expected_fractions.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_fractions.pop_front();
                    if (got.numerator !== want.numerator)
                    begin
                        $display("%0t: numerator expected %h actual %h", $time,
                                 want.numerator, got.numerator);
                        errors++;
                    end
                    if (got.exponent !== want.exponent)
                    begin
                        $display("%0t: exponent expected %0d actual %0d", $time,
                                 want.exponent, got.exponent);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_value(64'h0000_0000_0000_0000);   // zero
        send_value(64'h8000_0000_0000_0000);   // negative zero
        send_value(64'h3FF0_0000_0000_0000);   // one
        send_value(64'h3FE0_0000_0000_0000);   // one half
        send_value(64'h3FD5_5555_5555_5555);   // one third, stops at limit
        send_value(64'h3FEF_FFFF_FFFF_FFFF);   // just below one
        send_value(64'h3FF0_0000_0000_0001);   // just above one
        send_value(64'h7FF8_0000_0000_0000);   // NaN
        send_value(64'hFFFF_FFFF_FFFF_FFFF);   // negative NaN
        send_value(64'hBFE0_0000_0000_0000);   // negative value
        send_value(64'h7FF0_0000_0000_0000);   // infinity
        send_value(64'h0000_0000_0000_0001);   // smallest subnormal
        send_value(64'h000F_FFFF_FFFF_FFFF);   // largest subnormal
        send_value(64'h3000_0000_0000_0000);   // tiny, exact only at the largest exponent
        send_value(64'h3FB9_9999_9999_999A);   // 0.1
        wait_drained();
        // Values that hit the limit of one before they become exact.
        write_limit(6'd1);
        send_value(64'h3FE0_0000_0000_0000);
        send_value(64'h3FD0_0000_0000_0000);
        send_value(64'h3FD5_5555_5555_5555);
        wait_drained();
        write_limit(6'd0);
        send_value(64'h3FD5_5555_5555_5555);   // limit of zero
        send_value(64'h3FE8_0000_0000_0000);
        wait_drained();
        write_limit(6'd63);
        send_value(64'h3FD5_5555_5555_5555);
        send_value(64'h3FB9_9999_9999_999A);
        send_value(64'h3F50_0000_0000_0001);
        wait_drained();
    endtask

    task automatic test_random_at(logic [5:0] bits, int count);
        write_limit(bits);
        repeat (count) send_value(pick_value());
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_at(6'd31, 150);
        test_random_at(6'd63, 150);
        test_random_at(6'd1, 100);
        test_random_at(6'($urandom_range(2, 62)), 150);
        test_random_at(6'($urandom_range(2, 20)), 150);
        idle_enabled = 1'b0;
        test_random_at(6'($urandom_range(1, 63)), 225);
        $display("Covered directed edge values and %0d results over limits 0, 1, 31, 63",
                 results_seen);
        $display("and random limits, with random stalls on both sides.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
